@@ hdl/assert_macros.svh @@
// Shared assertion macros. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Invariant that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	`ASSERT_CLK(label, (expr), msg)

`endif

@@ hdl/aabb_pkg.sv @@
`timescale 1ns / 1ps
package aabb_pkg;

	localparam int WORD_W    = 32;
	localparam int Q_FRAC    = 16;
	localparam int FULL_W    = 2 * WORD_W;
	localparam int PROD_W    = FULL_W - Q_FRAC;
	localparam int SUM_W     = PROD_W + 2;
	localparam int NUM_AXES  = 3;
	localparam int NUM_WORDS = 12;
	localparam int NUM_REGS  = 6;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [FULL_W-1:0] full_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [CFG_W-1:0]         cfg_word_t;

	// Identity transform after reset
	localparam cfg_word_t CFG_RST [NUM_REGS] = '{
		64'd65536, 64'd0, 64'd65536, 64'd0, 64'd65536, 64'd0
	};

	// Load strobes for the four pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_ld_t;

	// Clamp a wide sum to the 32-bit signed range
	function automatic word_t sat_word(input sum_t v);
		logic fits;
		fits = (v[SUM_W-1:WORD_W-1] == '0) || (v[SUM_W-1:WORD_W-1] == '1);
		if (fits) begin
			return v[WORD_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(WORD_W-1){1'b1}}};
		end
	endfunction

endpackage

@@ hdl/aabb_axis.sv @@
`timescale 1ns / 1ps
// One output axis: products, min/max pick, split sum, saturate.
module aabb_axis (
	input  logic              clk,
	input  aabb_pkg::stage_ld_t ld,
	input  aabb_pkg::word_t   coef [aabb_pkg::NUM_AXES],
	input  aabb_pkg::word_t   trans,
	input  aabb_pkg::word_t   lo   [aabb_pkg::NUM_AXES],
	input  aabb_pkg::word_t   hi   [aabb_pkg::NUM_AXES],
	output aabb_pkg::word_t   res_min,
	output aabb_pkg::word_t   res_max
);
	import aabb_pkg::*;

	full_t full_lo [NUM_AXES];
	full_t full_hi [NUM_AXES];
	prod_t plo_s1  [NUM_AXES];
	prod_t phi_s1  [NUM_AXES];
	prod_t pmin_s2 [NUM_AXES];
	prod_t pmax_s2 [NUM_AXES];
	sum_t  mn_a_s3, mn_b_s3, mx_a_s3, mx_b_s3;
	word_t mn_s4, mx_s4;

	// Full products; the shift by 16 is the top bits (floor rounding)
	always_comb begin
		for (int j = 0; j < NUM_AXES; j++) begin
			full_lo[j] = coef[j] * lo[j];
			full_hi[j] = coef[j] * hi[j];
		end
	end

	// Stage 1: scaled products
	always_ff @(posedge clk) begin
		if (ld.s1) begin
			for (int j = 0; j < NUM_AXES; j++) begin
				plo_s1[j] <= prod_t'(full_lo[j] >>> Q_FRAC);
				phi_s1[j] <= prod_t'(full_hi[j] >>> Q_FRAC);
			end
		end
	end

	// Stage 2: smaller product to min, larger to max
	always_ff @(posedge clk) begin
		if (ld.s2) begin
			for (int j = 0; j < NUM_AXES; j++) begin
				if (plo_s1[j] < phi_s1[j]) begin
					pmin_s2[j] <= plo_s1[j];
					pmax_s2[j] <= phi_s1[j];
				end else begin
					pmin_s2[j] <= phi_s1[j];
					pmax_s2[j] <= plo_s1[j];
				end
			end
		end
	end

	// Stage 3: two partial sums per bound
	always_ff @(posedge clk) begin
		if (ld.s3) begin
			mn_a_s3 <= sum_t'(trans) + sum_t'(pmin_s2[0]);
			mn_b_s3 <= sum_t'(pmin_s2[1]) + sum_t'(pmin_s2[2]);
			mx_a_s3 <= sum_t'(trans) + sum_t'(pmax_s2[0]);
			mx_b_s3 <= sum_t'(pmax_s2[1]) + sum_t'(pmax_s2[2]);
		end
	end

	// Stage 4: final add and clamp into the output register
	always_ff @(posedge clk) begin
		if (ld.s4) begin
			mn_s4 <= sat_word(mn_a_s3 + mn_b_s3);
			mx_s4 <= sat_word(mx_a_s3 + mx_b_s3);
		end
	end

	assign res_min = mn_s4;
	assign res_max = mx_s4;

endmodule

@@ hdl/aabb_affine_transform.sv @@
`timescale 1ns / 1ps
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------------
// in       | in_valid / in_ready    | in_min_x..z, in_max_x..z (Q16.16 signed)
// out      | out_valid / out_ready  | out_min_x..z, out_max_x..z (Q16.16, sat.)
// cfg      | cfg_wr_en              | cfg_index, cfg_wdata (six 64-bit words)
//
// One box per cycle while the output is not stalled; the four stages are
// multiply, min/max pick, partial sums, and final sum with saturation.
// Reset clears the stage valid bits and loads the identity transform.
// Each stage holds while the one after it is full and stalled; empty
// stages still take items, so in_ready drops only once all four are full.
module aabb_affine_transform (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [aabb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  aabb_pkg::cfg_word_t   cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  aabb_pkg::word_t       in_min_x,
	input  aabb_pkg::word_t       in_min_y,
	input  aabb_pkg::word_t       in_min_z,
	input  aabb_pkg::word_t       in_max_x,
	input  aabb_pkg::word_t       in_max_y,
	input  aabb_pkg::word_t       in_max_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output aabb_pkg::word_t       out_min_x,
	output aabb_pkg::word_t       out_min_y,
	output aabb_pkg::word_t       out_min_z,
	output aabb_pkg::word_t       out_max_x,
	output aabb_pkg::word_t       out_max_y,
	output aabb_pkg::word_t       out_max_z
);
	import aabb_pkg::*;

	cfg_word_t cfg_q [NUM_REGS];
	word_t     mat_w [NUM_WORDS];
	word_t     lo    [NUM_AXES];
	word_t     hi    [NUM_AXES];
	word_t     res_min [NUM_AXES];
	word_t     res_max [NUM_AXES];
	logic      vld_s1, vld_s2, vld_s3, vld_s4;
	logic      rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	stage_ld_t ld;

	// Transform registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				cfg_q[r] <= CFG_RST[r];
			end
		end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
			cfg_q[cfg_index] <= cfg_wdata;
		end
	end

	// Word k: low half of register k/2 for even k, high half for odd k
	always_comb begin
		for (int r = 0; r < NUM_REGS; r++) begin
			mat_w[2*r]   = cfg_q[r][WORD_W-1:0];
			mat_w[2*r+1] = cfg_q[r][CFG_W-1:WORD_W];
		end
	end

	assign lo[0] = in_min_x;
	assign lo[1] = in_min_y;
	assign lo[2] = in_min_z;
	assign hi[0] = in_max_x;
	assign hi[1] = in_max_y;
	assign hi[2] = in_max_z;

	// Stage flow control: a stage loads when empty or when its successor moves
	assign rdy_s4   = !vld_s4 || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign ld       = '{s1: rdy_s1, s2: rdy_s2, s3: rdy_s3, s4: rdy_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	// One datapath per output axis; coefficient for input axis j is word 3j+i
	for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
		word_t coef [NUM_AXES];
		for (genvar j = 0; j < NUM_AXES; j++) begin : g_coef
			assign coef[j] = mat_w[NUM_AXES*j + i];
		end
		aabb_axis u_axis (
			.clk     (clk),
			.ld      (ld),
			.coef    (coef),
			.trans   (mat_w[NUM_AXES*NUM_AXES + i]),
			.lo      (lo),
			.hi      (hi),
			.res_min (res_min[i]),
			.res_max (res_max[i])
		);
	end

	assign out_valid = vld_s4;
	assign out_min_x = res_min[0];
	assign out_min_y = res_min[1];
	assign out_min_z = res_min[2];
	assign out_max_x = res_max[0];
	assign out_max_y = res_max[1];
	assign out_max_z = res_max[2];

endmodule

@@ hdl/aabb_affine_transform_chk.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks for the box transform.
module aabb_affine_transform_chk (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  aabb_pkg::word_t       out_min_x,
	input  aabb_pkg::word_t       out_min_y,
	input  aabb_pkg::word_t       out_min_z,
	input  aabb_pkg::word_t       out_max_x,
	input  aabb_pkg::word_t       out_max_y,
	input  aabb_pkg::word_t       out_max_z
);
	logic [2:0] cnt_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Items inside the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else begin
			cnt_q <= cnt_q + {2'b00, in_acc} - {2'b00, out_acc};
		end
	end

	// A stalled result stays valid and holds its x bounds and its min z
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_min_x) && $stable(out_max_x) && $stable(out_min_z), "stalled item changed")

	// Min pick never exceeds max pick, so the output box is never inverted
	`ASSERT_ALWAYS(a_box_order, !out_valid || (out_min_x <= out_max_x && out_min_y <= out_max_y && out_min_z <= out_max_z), "output min above max")

	// Input back-pressure only when the output itself is stalled
	`ASSERT_ALWAYS(a_no_idle_stall, in_ready || (out_valid && !out_ready), "input stalled with output free")

	// Four stages hold at most four items
	`ASSERT_ALWAYS(a_occupancy, cnt_q <= 3'd4, "more items in flight than stages")

	// No result without an item inside
	`ASSERT_ALWAYS(a_no_phantom, cnt_q != 3'd0 || !out_valid, "result with empty pipeline")

endmodule

bind aabb_affine_transform aabb_affine_transform_chk u_chk (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import aabb_pkg::*;

	// Six box words: 0..2 min x/y/z, 3..5 max x/y/z
	typedef logic [5:0][WORD_W-1:0] box_t;
	// Twelve transform words: 0..8 m[row][col], 9..11 translation
	typedef logic [NUM_WORDS-1:0][WORD_W-1:0] matrix_t;

	localparam logic [CFG_IDX_W-1:0] REG_M00_M01 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_M02_M10 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_M11_M12 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_M20_M21 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_M22_TX  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TY_TZ   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam word_t W_MAX    = 32'sh7fff_ffff;
	localparam word_t W_MIN    = 32'sh8000_0000;
	localparam word_t Q_ONE    = 32'sh0001_0000;
	localparam word_t Q_HALF   = 32'sh0000_8000;
	localparam int    LATENCY  = 4;
	localparam int    HOLD_LEN = 300;
	localparam int    MAX_SHOW = 10;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	cfg_word_t cfg_wdata = '0;
	logic  in_valid  = 1'b0;
	logic  in_ready;
	word_t in_min_x  = '0;
	word_t in_min_y  = '0;
	word_t in_min_z  = '0;
	word_t in_max_x  = '0;
	word_t in_max_y  = '0;
	word_t in_max_z  = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	word_t out_min_x;
	word_t out_min_y;
	word_t out_min_z;
	word_t out_max_x;
	word_t out_max_y;
	word_t out_max_z;

	// Predictor copy of the transform
	word_t matrix_q [NUM_WORDS];
	box_t  expected_boxes [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;
	int hold_end       = 0;
	int boxes_sent     = 0;
	int boxes_checked  = 0;
	int settings_loaded = 0;
	int mismatches     = 0;
	int strays         = 0;
	string axis_chars  = "xyz";

	aabb_affine_transform u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_min_x  (in_min_x),
		.in_min_y  (in_min_y),
		.in_min_z  (in_min_z),
		.in_max_x  (in_max_x),
		.in_max_y  (in_max_y),
		.in_max_z  (in_max_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_min_x (out_min_x),
		.out_min_y (out_min_y),
		.out_min_z (out_min_z),
		.out_max_x (out_max_x),
		.out_max_y (out_max_y),
		.out_max_z (out_max_z)
	);

	always #1 clk = ~clk;

	// Clamp an exact sum to the signed 32-bit range
	function automatic word_t clamp_word(longint s);
		if (s > 64'sd2147483647)
			return W_MAX;
		if (s < -64'sd2147483648)
			return W_MIN;
		return s[WORD_W-1:0];
	endfunction

	// Enclosing box of the transformed box
	function automatic box_t transform_box(box_t b);
		box_t   r;
		longint acc_lo, acc_hi, c, pa, pb;
		int     i, j;
		for (i = 0; i < NUM_AXES; i++) begin
			acc_lo = matrix_q[9 + i];
			acc_hi = acc_lo;
			for (j = 0; j < NUM_AXES; j++) begin
				c  = matrix_q[3 * j + i];
				// floor division by 2^16
				pa = (c * longint'($signed(b[j]))) >>> Q_FRAC;
				pb = (c * longint'($signed(b[3 + j]))) >>> Q_FRAC;
				if (pa < pb) begin
					acc_lo += pa;
					acc_hi += pb;
				end else begin
					acc_lo += pb;
					acc_hi += pa;
				end
			end
			r[i]     = clamp_word(acc_lo);
			r[3 + i] = clamp_word(acc_hi);
		end
		return r;
	endfunction

	function automatic box_t mk_box(word_t x0, word_t y0, word_t z0,
			word_t x1, word_t y1, word_t z1);
		return {z1, y1, x1, z0, y0, x0};
	endfunction

	// Mix of full-range, small, tiny and corner values
	function automatic word_t rand_word();
		case ($urandom_range(7))
			0, 1, 2: return $urandom;
			3, 4:    return $urandom_range(2097152) - 1048576;
			5: case ($urandom_range(4))
				0:       return W_MAX;
				1:       return W_MIN;
				2:       return 0;
				3:       return -1;
				default: return 1;
			endcase
			default: return $urandom_range(1023) - 512;
		endcase
	endfunction

	// Coefficients mostly within +-4.0 so sums stay mostly in range
	function automatic word_t rand_coef();
		case ($urandom_range(5))
			0:       return $urandom;
			1:       return 0;
			2:       return $urandom_range(1) ? Q_ONE : -Q_ONE;
			default: return $urandom_range(524288) - 262144;
		endcase
	endfunction

	function automatic matrix_t rand_matrix();
		matrix_t m;
		int      k;
		for (k = 0; k < 9; k++)
			m[k] = rand_coef();
		for (k = 9; k < NUM_WORDS; k++)
			m[k] = rand_word();
		return m;
	endfunction

	// Mostly well-formed boxes, some inverted, degenerate or raw
	function automatic box_t rand_box();
		box_t  b;
		word_t a, c, t;
		int    j, kind;
		kind = $urandom_range(9);
		for (j = 0; j < NUM_AXES; j++) begin
			a = rand_word();
			c = rand_word();
			if (kind == 8)
				c = a;
			else if ((kind < 6 && a > c) || ((kind == 6 || kind == 7) && a < c)) begin
				t = a;
				a = c;
				c = t;
			end
			b[j]     = a;
			b[3 + j] = c;
		end
		return b;
	endfunction

	// One register write; the predictor ignores spare indexes
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx < NUM_REGS) begin
			matrix_q[2 * idx]     = data[WORD_W-1:0];
			matrix_q[2 * idx + 1] = data[CFG_W-1:WORD_W];
		end
		@(posedge clk);
	endtask

	task automatic load_matrix(matrix_t m);
		write_reg(REG_M00_M01, {m[1], m[0]});
		write_reg(REG_M02_M10, {m[3], m[2]});
		write_reg(REG_M11_M12, {m[5], m[4]});
		write_reg(REG_M20_M21, {m[7], m[6]});
		write_reg(REG_M22_TX,  {m[9], m[8]});
		write_reg(REG_TY_TZ,   {m[11], m[10]});
		settings_loaded++;
	endtask

	// Offer one box, hold it until taken, then queue its prediction
	task automatic send_box(box_t b);
		logic taken;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_min_x <= b[0];
		in_min_y <= b[1];
		in_min_z <= b[2];
		in_max_x <= b[3];
		in_max_y <= b[4];
		in_max_z <= b[5];
		// ready is stable between the falling edge and the next rising edge
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		expected_boxes.push_back(transform_box(b));
		boxes_sent++;
	endtask

	// Stop offering and wait for the pipeline to empty
	task automatic finish_results();
		in_valid <= 1'b0;
		while (expected_boxes.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Reset transform, corner boxes, inverted and degenerate boxes
	task automatic test_identity();
		send_box(mk_box(0, 0, 0, 0, 0, 0));
		send_box(mk_box(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX));
		send_box(mk_box(W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN));
		send_box(mk_box(-Q_ONE, 32'sh1234_5678, -7, Q_ONE, 32'sh1234_5679, 9));
		send_box(mk_box(-3, 5, -7, -3, 5, -7));
		finish_results();
	endtask

	// Saturation both ways, zero matrix, floor rounding, dense mixed signs
	task automatic test_extreme_matrix();
		matrix_t m;
		m = {NUM_WORDS{W_MAX}};
		load_matrix(m);
		send_box(mk_box(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX));
		send_box(mk_box(0, 0, 0, 0, 0, 0));
		finish_results();

		m = {NUM_WORDS{W_MIN}};
		load_matrix(m);
		send_box(mk_box(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX));
		send_box(mk_box(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
		finish_results();

		// all products zero, result is the translation
		m = '0;
		m[9]  = W_MAX;
		m[10] = W_MIN;
		m[11] = Q_ONE;
		load_matrix(m);
		send_box(mk_box(W_MIN, 3, W_MAX, W_MAX, -3, W_MIN));
		finish_results();

		// negative half scale on the diagonal: odd inputs round down
		m = '0;
		m[0] = -Q_HALF;
		m[4] = -Q_HALF;
		m[8] = -Q_HALF;
		load_matrix(m);
		send_box(mk_box(1, -1, 3, -3, 7, -5));
		send_box(mk_box(-1, -1, -1, 1, 1, 1));
		finish_results();

		for (int k = 0; k < 9; k++)
			m[k] = (k % 2) ? -(Q_ONE + 32'sd3 * k) : (Q_HALF + 32'sd5 * k);
		m[9]  = -Q_ONE;
		m[10] = Q_HALF;
		m[11] = 32'sd17;
		load_matrix(m);
		send_box(mk_box(32'sh0003_4001, -32'sh0002_0003, 11, 32'sh0003_4001, -32'sh0002_0003, 11));
		send_box(mk_box(-32'sh0010_0001, 32'sh0000_0fff, -1, 32'sh0020_0003, 32'sh0001_0001, 1));
		finish_results();
	endtask

	// Writes to the unused indexes must leave the transform alone
	task automatic test_spare_index();
		write_reg(REG_SPARE_6, '1);
		write_reg(REG_SPARE_7, {$urandom, $urandom});
		send_box(mk_box(-5, 7, -9, 32'sh0001_8003, 13, 15));
		send_box(rand_box());
		finish_results();
	endtask

	// Four idling modes, four random transforms each
	task automatic test_random_traffic();
		int phase, blk;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			for (blk = 0; blk < 4; blk++) begin
				load_matrix(rand_matrix());
				repeat (70) send_box(rand_box());
				finish_results();
			end
		end
	endtask

	// Long output stall while the input keeps offering
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		load_matrix(rand_matrix());
		@(negedge clk);
		hold_end = cycle_count + HOLD_LEN;
		@(posedge clk);
		repeat (40) send_box(rand_box());
		finish_results();
	endtask

	// Input pauses until every result is out, then resumes
	task automatic test_pause();
		send_idle_pct  = 20;
		recv_stall_pct = 20;
		repeat (20) send_box(rand_box());
		finish_results();
		repeat (20) send_box(rand_box());
		finish_results();
	endtask

	// Output ready: random stalls, or held low up to hold_end
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (!arst_n || cycle_count < hold_end)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each result taken at the coming edge with the oldest prediction
	always @(negedge clk) begin
		box_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {out_max_z, out_max_y, out_max_x, out_min_z, out_min_y, out_min_x};
			if (expected_boxes.size() == 0) begin
				if (mismatches + strays < MAX_SHOW)
					$display("result %0d with no box pending: %h", boxes_checked, got);
				strays++;
			end else begin
				want = expected_boxes.pop_front();
				for (int k = 0; k < 6; k++) begin
					if (got[k] !== want[k]) begin
						if (mismatches + strays < MAX_SHOW)
							$display("result %0d out_%s_%c: expected %h, got %h",
								boxes_checked, (k < 3) ? "min" : "max",
								axis_chars[k % 3], want[k], got[k]);
						mismatches++;
					end
				end
			end
			boxes_checked++;
		end
	end

	initial begin
		for (int k = 0; k < NUM_WORDS; k++)
			matrix_q[k] = (k == 0 || k == 4 || k == 8) ? Q_ONE : '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity();
		test_extreme_matrix();
		test_spare_index();
		test_random_traffic();
		test_backpressure();
		test_pause();

		$display("Sent %0d boxes, checked %0d results over %0d transforms, with idling, stalls",
			boxes_sent, boxes_checked, settings_loaded);
		$display("and a %0d-cycle output hold; %0d field mismatches, %0d stray, %0d missing.",
			HOLD_LEN, mismatches, strays, expected_boxes.size());
		if (mismatches == 0 && strays == 0 && expected_boxes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("Timeout with %0d results still pending", expected_boxes.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
